>>> rtl/rgbdg_pkg.sv
// Package for the RGB565 decimating grayscale converter.
// Frame geometry, register indexes and the gray arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgbdg_pkg;

   localparam int FRAME_WIDTH  = 320;
   localparam int FRAME_HEIGHT = 240;

   localparam int COL_W       = 9;
   localparam int ROW_W       = 8;
   localparam int SHIFT_W     = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam int SUM_W       = 13;

   // floor(x / 100) == (x * 5243) >> 19 for every x up to the largest sum
   localparam int RECIP       = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCALE_SHIFT = 1'b0,
      CSR_GRAY_MODE   = 1'b1
   } csr_index_type;

   // 21r + 72g + 7b on the raw fields
   function automatic logic [SUM_W-1:0] gray_sum(input logic [15:0] px);
      logic [SUM_W-1:0] r;
      logic [SUM_W-1:0] g;
      logic [SUM_W-1:0] b;
      r = SUM_W'(px[15:11]);
      g = SUM_W'(px[10:5]);
      b = SUM_W'(px[4:0]);
      return SUM_W'(r * SUM_W'(21) + g * SUM_W'(72) + b * SUM_W'(7));
   endfunction

   // twice the quotient by 100
   function automatic logic [7:0] gray_byte(input logic [SUM_W-1:0] sum);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(sum) * PROD_W'(RECIP);
      return {prod[RECIP_SHIFT +: 7], 1'b0};
   endfunction

endpackage

`default_nettype wire

>>> rtl/rgbdg_frame_pos.sv
// Frame position tracker for the RGB565 decimating grayscale converter.
// Keeps column/row of the next pixel and flags pixels on the decimation grid.
// Depends on rgbdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbdg_frame_pos (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [rgbdg_pkg::SHIFT_W-1:0] scale_shift,
   output logic                               keep
);

   logic [rgbdg_pkg::COL_W-1:0] col_ff;
   logic [rgbdg_pkg::COL_W-1:0] col_in;
   logic [rgbdg_pkg::ROW_W-1:0] row_ff;
   logic [rgbdg_pkg::ROW_W-1:0] row_in;
   logic [rgbdg_pkg::ROW_W-1:0] mask;

   assign mask      = (rgbdg_pkg::ROW_W'(1) << scale_shift) - rgbdg_pkg::ROW_W'(1);
   assign keep      = ((col_ff[rgbdg_pkg::ROW_W-1:0] & mask) == '0)
                      && ((row_ff & mask) == '0);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (col_ff >= rgbdg_pkg::COL_W'(rgbdg_pkg::FRAME_WIDTH - 1)) begin
            col_in = '0;
            if (row_ff >= rgbdg_pkg::ROW_W'(rgbdg_pkg::FRAME_HEIGHT - 1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + rgbdg_pkg::ROW_W'(1);
            end
         end else begin
            col_in = col_ff + rgbdg_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/rgb565_decimate_grayscale_top.sv
// Top level of the RGB565 decimating grayscale converter.
// Depends on rgbdg_pkg and rgbdg_frame_pos.
//
// Takes one RGB565 pixel per request on a fixed 320x240 raster and keeps
// only pixels whose row and column are multiples of 2^scale_shift. A kept
// pixel gives one byte 2*floor((21r+72g+7b)/100) in gray mode, or the low
// then the high color byte otherwise; rsp_last marks its final byte.
// A new pixel is taken once any kept pixel before it has handed its last byte
// to the single byte-wide result register; each byte passes a stage-1 register,
// then the result register. Write the registers only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module rgb565_decimate_grayscale_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [15:0]                       req_pixel,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [7:0]                             rsp_out_byte,
   output logic                                   rsp_last,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rgbdg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rgbdg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [rgbdg_pkg::SHIFT_W-1:0] scale_ff;
   logic                          gray_ff;

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic                          s1_phase_ff;
   logic                          s1_phase_in;
   logic                          s1_gray_ff;
   logic [15:0]                   s1_px_ff;
   logic [rgbdg_pkg::SUM_W-1:0]   s1_sum_ff;

   logic                          out_valid_ff;
   logic [7:0]                    out_byte_ff;
   logic [7:0]                    out_byte_in;
   logic                          out_last_ff;

   logic                          keep;
   logic                          req_fire;
   logic                          out_load;
   logic                          s1_emit;
   logic                          s1_last;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
         gray_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (rgbdg_pkg::csr_index_type'(csr_index))
            rgbdg_pkg::CSR_SCALE_SHIFT: scale_ff <= csr_wdata[rgbdg_pkg::SHIFT_W-1:0];
            rgbdg_pkg::CSR_GRAY_MODE:   gray_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   rgbdg_frame_pos u_pos (
      .clock       (clock),
      .reset       (reset),
      .step        (req_fire),
      .scale_shift (scale_ff),
      .keep        (keep)
   );

   assign out_load  = !out_valid_ff || rsp_ready;
   assign s1_emit   = s1_valid_ff && out_load;
   assign s1_last   = s1_gray_ff || s1_phase_ff;
   assign req_ready = !s1_valid_ff || (s1_emit && s1_last);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_phase_in = s1_phase_ff;
      if (req_fire) begin
         s1_valid_in = keep;
         s1_phase_in = 1'b0;
      end else if (s1_emit) begin
         if (s1_last) begin
            s1_valid_in = 1'b0;
         end else begin
            s1_phase_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (s1_gray_ff) begin
         out_byte_in = rgbdg_pkg::gray_byte(s1_sum_ff);
      end else if (s1_phase_ff) begin
         out_byte_in = s1_px_ff[15:8];
      end else begin
         out_byte_in = s1_px_ff[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_phase_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_phase_ff <= s1_phase_in;
         if (out_load) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_px_ff   <= req_pixel;
         s1_sum_ff  <= rgbdg_pkg::gray_sum(req_pixel);
         s1_gray_ff <= gray_ff;
      end
      if (out_load) begin
         out_byte_ff <= out_byte_in;
         out_last_ff <= s1_last;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;

endmodule

`default_nettype wire

>>> rtl/rgbdg_checker.sv
// Port-level checker for the RGB565 decimating grayscale converter.
// Watches the top level's ports only; bound to rgb565_decimate_grayscale_top.
// Depends on rgb565_decimate_grayscale_top.
`timescale 1ns / 1ps
`default_nettype none

module rgbdg_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last,
   input wire logic       csr_ready
);

   // a held result keeps its byte and flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("rsp changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // high color byte follows the low one without a gap
   a_color_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last)
      else $error("second color byte missing");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr write stalled");

endmodule

bind rgb565_decimate_grayscale_top rgbdg_checker u_rgbdg_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_last     (rsp_last),
   .csr_ready    (csr_ready)
);

`default_nettype wire

>>> dv/rgb565_decimate_grayscale_checker.sv
// Checker for rgb565_decimate_grayscale_top: watches the request, response and
// register channels, predicts every response byte and compares it. Uses rgbdg_pkg.
`timescale 1ns / 1ps

module rgb565_decimate_grayscale_checker
   import rgbdg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [15:0]            req_pixel,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [7:0]             rsp_out_byte,
   input  logic                   rsp_last,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     bytes_due
);

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } rsp_beat_type;

   rsp_beat_type     expected_bytes[$];
   rsp_beat_type     beat;
   logic [SHIFT_W-1:0] shift_cfg;
   logic             gray_cfg;
   logic [COL_W-1:0] col_next;
   logic [ROW_W-1:0] row_next;

   initial begin
      fail_count = 0;
      bytes_due  = 0;
   end

   task automatic report(input string what, input int got, input int want);
      if (fail_count < 100) begin
         $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      end
      fail_count++;
   endtask

   function automatic logic [7:0] gray_level_x2(input logic [15:0] px);
      int unsigned weighted;
      weighted = 21 * px[15:11] + 72 * px[10:5] + 7 * px[4:0];
      return 8'((weighted / 100) * 2);
   endfunction

   task automatic predict_pixel(input logic [15:0] px);
      logic [COL_W-1:0] mask;
      mask = (COL_W'(1) << shift_cfg) - COL_W'(1);
      if (((row_next & mask[ROW_W-1:0]) == '0) && ((col_next & mask) == '0)) begin
         if (gray_cfg) begin
            expected_bytes.push_back('{data: gray_level_x2(px), last: 1'b1});
         end else begin
            expected_bytes.push_back('{data: px[7:0], last: 1'b0});
            expected_bytes.push_back('{data: px[15:8], last: 1'b1});
         end
      end
      if (col_next == COL_W'(FRAME_WIDTH - 1)) begin
         col_next = '0;
         row_next = (row_next == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : row_next + 1'b1;
      end else begin
         col_next = col_next + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shift_cfg = '0;
         gray_cfg  = 1'b0;
         col_next  = '0;
         row_next  = '0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report("unexpected response byte", rsp_out_byte, 0);
            end else begin
               beat = expected_bytes.pop_front();
               if (rsp_out_byte !== beat.data) report("rsp_out_byte", rsp_out_byte, beat.data);
               if (rsp_last !== beat.last) report("rsp_last", rsp_last, beat.last);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_SCALE_SHIFT: shift_cfg = csr_wdata[SHIFT_W-1:0];
               CSR_GRAY_MODE:   gray_cfg  = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_pixel(req_pixel);
      end
      bytes_due = expected_bytes.size();
   end

endmodule

>>> dv/rgb565_decimate_grayscale_top_tb.sv
// Testbench top for rgb565_decimate_grayscale_top: drives pixel requests and
// register writes, stalls the response side, and gives the verdict.
// Depends on rgbdg_pkg, the block and rgb565_decimate_grayscale_checker.
`timescale 1ns / 1ps

module rgb565_decimate_grayscale_top_tb;
   import rgbdg_pkg::*;

   localparam int RANDOM_ITEMS = 640;
   localparam int DRAIN_CYCLES = 4;
   localparam int QUIET_LIMIT  = 2000;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [15:0]            req_pixel = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_out_byte;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     fail_count;
   int                     bytes_due;

   int burst_left = 1;
   int gap_max    = 0;
   int ready_hold = 0;

   always #5 clock = ~clock;

   rgb565_decimate_grayscale_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_pixel(req_pixel),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   rgb565_decimate_grayscale_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_pixel(req_pixel),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .bytes_due(bytes_due)
   );

   // response backpressure: runs of ready and stall of random length
   always @(negedge clock) begin
      if (ready_hold == 0) begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
         ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
      end else begin
         ready_hold--;
      end
   end

   function automatic logic [15:0] random_pixel();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'hF800;
         3:       return 16'h07E0;
         4:       return 16'h001F;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_pixel(input logic [15:0] px);
      @(negedge clock);
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gap_max > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge clock);
         end
      end
   endtask

   task automatic sender_idle();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // wait for every predicted byte, then for a dropped pixel still in flight
   task automatic await_drain();
      @(negedge clock);
      while (bytes_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [SHIFT_W-1:0] shift, input logic gray);
      logic [CSR_DATA_W-1:0] value;
      value = CSR_DATA_W'($urandom);
      value[SHIFT_W-1:0] = shift;
      write_csr(CSR_SCALE_SHIFT, value);
      value = CSR_DATA_W'($urandom);
      value[0] = gray;
      write_csr(CSR_GRAY_MODE, value);
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int random_items;
      int count;
      logic [SHIFT_W-1:0] shift;
      random_items = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset config: full rate, color bytes
      gap_max = 2;
      send_pixel(16'h0000);
      send_pixel(16'hFFFF);
      send_pixel(16'hF800);
      send_pixel(16'h07E0);
      send_pixel(16'h001F);
      send_pixel(16'h1234);
      sender_idle();
      await_drain();

      // gray mode, upper data bits set
      write_csr(CSR_GRAY_MODE, 8'hFF);
      send_pixel(16'h0000);
      send_pixel(16'hFFFF);
      send_pixel(16'hF800);
      send_pixel(16'h07E0);
      send_pixel(16'h001F);
      sender_idle();
      await_drain();

      // decimate by 2 mid-row: position is kept, odd columns dropped
      write_csr(CSR_SCALE_SHIFT, 8'h01);
      send_pixel(16'hAAAA);
      send_pixel(16'h5555);
      send_pixel(16'hFFFF);
      send_pixel(16'h0001);
      sender_idle();
      await_drain();

      write_csr(CSR_GRAY_MODE, 8'hFE);
      send_pixel(16'h8421);
      send_pixel(16'h7BDE);
      sender_idle();
      await_drain();

      write_csr(CSR_SCALE_SHIFT, 8'hFF);
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
      send_pixel(16'hC3C3);
      sender_idle();
      await_drain();

      // largest factor past a row end: column wraps and the row advances
      set_config(3'd7, 1'b0);
      gap_max = 0;
      repeat (FRAME_WIDTH + 20) send_pixel(16'($urandom));
      sender_idle();
      await_drain();

      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       shift = 3'd0;
            1:       shift = 3'd7;
            default: shift = SHIFT_W'($urandom_range(0, 3));
         endcase
         set_config(shift, 1'($urandom));
         case ($urandom_range(0, 2))
            0:       gap_max = 0;
            1:       gap_max = 3;
            default: gap_max = 12;
         endcase
         count = $urandom_range(10, 60);
         repeat (count) send_pixel(random_pixel());
         random_items += count;
         sender_idle();
         await_drain();
      end

      repeat (8) @(negedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> sim.f
rtl/rgbdg_pkg.sv
rtl/rgbdg_frame_pos.sv
rtl/rgb565_decimate_grayscale_top.sv
rtl/rgbdg_checker.sv
dv/rgb565_decimate_grayscale_checker.sv
dv/rgb565_decimate_grayscale_top_tb.sv
